/* src/tfst_pkg.sv */
// tfst_pkg: shared types and constants of the timed flash slot table
// operation codes, sequencer states and field widths; no dependencies
`default_nettype none

package tfst_pkg;

	// field widths of one input word and one result word
	localparam int KIND_W      = 2;
	localparam int FLASH_W     = 2;
	localparam int TARGET_W    = 4;
	localparam int IDENT_W     = 8;
	localparam int TIME_W      = 16;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 8;

	// flash duration after reset
	localparam logic [TIME_W-1:0] DURATION_RESET = 16'd500;

	// operation codes carried in s_tuser
	typedef logic [KIND_W-1:0] op_t;
	localparam op_t OP_EMIT  = 2'd0;
	localparam op_t OP_TICK  = 2'd1;
	localparam op_t OP_QUERY = 2'd2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

/* src/timed_flash_slot_table.sv */
// timed_flash_slot_table: slot table of timed feedback entries with emit, tick and query
// depends on tfst_pkg
//
//  channel  | direction | handshake            | payload
//  s        | in        | s_tvalid / s_tready  | s_tuser kind, s_tdata emit/tick/query fields
//  m        | out       | m_tvalid / m_tready  | m_tuser hit, m_tdata hit_kind
//  cfg      | in        | cfg_wen              | cfg_wdata flash_duration
//
// one shared compare/subtract unit visits one slot per cycle under a small sequencer
// tick visits all slots; query stops at the first match or last slot, then gives its result; emit
// stops at an exact match or free slot, else replaces the slot with least time; unused kinds drop
// s_tready is low while a word is being worked on; a query result waits in its
// state until the output register is free, so m_tready stalls hold off the next word
// reset clears all slots to free and the duration to 500 at once
`default_nettype none

module timed_flash_slot_table #(
	parameter int SLOT_COUNT = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // flash_kind[1:0], target_class[5:2], element_id[13:6], elapsed[29:14], zero[31:30]
	input  wire logic [1:0]  s_tuser,  // kind[1:0]
	// result words
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // hit_kind[1:0], zero[7:2]
	output logic [0:0]       m_tuser,  // hit[0]
	// configuration
	input  wire logic        cfg_wen,
	input  wire logic [15:0] cfg_wdata
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	// slot storage
	logic [tfst_pkg::FLASH_W-1:0]  slot_flash_q  [SLOT_COUNT];
	logic [tfst_pkg::TARGET_W-1:0] slot_target_q [SLOT_COUNT];
	logic [tfst_pkg::IDENT_W-1:0]  slot_ident_q  [SLOT_COUNT];
	logic [tfst_pkg::TIME_W-1:0]   slot_rem_q    [SLOT_COUNT];

	// sequencer and latched word
	tfst_pkg::state_t              state_q, state_d;
	tfst_pkg::op_t                 op_q;
	logic [tfst_pkg::FLASH_W-1:0]  fk_q;
	logic [tfst_pkg::TARGET_W-1:0] tc_q;
	logic signed [tfst_pkg::IDENT_W-1:0] id_q;
	logic [tfst_pkg::TIME_W-1:0]   dt_q;
	logic [IDX_W-1:0]              idx_q;
	logic [tfst_pkg::TIME_W-1:0]   duration_q;

	// eviction tracking
	logic                          have_q;
	logic [IDX_W-1:0]              victim_q;
	logic [tfst_pkg::TIME_W-1:0]   best_q;

	// query result and output register
	logic                          res_hit_q;
	logic [tfst_pkg::FLASH_W-1:0]  res_kind_q;
	logic                          m_valid_q;
	logic                          m_hit_q;
	logic [tfst_pkg::FLASH_W-1:0]  m_kind_q;

	// shared unit signals
	logic [tfst_pkg::TIME_W-1:0]   rem_cur;
	logic                          cur_active;
	logic                          exact;
	logic                          qmatch;
	logic                          better;
	logic                          last;
	logic [tfst_pkg::TIME_W-1:0]   tick_val;

	// control
	logic                          accept;
	logic                          out_free;
	logic                          out_load;
	logic                          ent_we;
	logic                          rem_we;
	logic [IDX_W-1:0]              wr_idx;
	logic [tfst_pkg::TIME_W-1:0]   rem_wval;
	logic                          track;

	// compare and subtract on the visited slot
	always_comb begin
		rem_cur    = slot_rem_q[idx_q];
		cur_active = (rem_cur != '0);
		exact      = cur_active && (slot_flash_q[idx_q] == fk_q)
			&& (slot_target_q[idx_q] == tc_q) && (slot_ident_q[idx_q] == id_q);
		qmatch     = cur_active && (slot_target_q[idx_q] == tc_q)
			&& (slot_ident_q[idx_q][tfst_pkg::IDENT_W-1] || (slot_ident_q[idx_q] == id_q));
		better     = !have_q || (rem_cur < best_q);
		last       = (idx_q == LAST_IDX);
		tick_val   = (rem_cur > dt_q) ? (rem_cur - dt_q) : '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tfst_pkg::ST_IDLE: begin
				if (s_tvalid && (s_tuser == tfst_pkg::OP_EMIT || s_tuser == tfst_pkg::OP_TICK
					|| s_tuser == tfst_pkg::OP_QUERY)) begin
					state_d = tfst_pkg::ST_SCAN;
				end
			end
			tfst_pkg::ST_SCAN: begin
				case (op_q)
					tfst_pkg::OP_EMIT: begin
						if (exact || !cur_active) state_d = tfst_pkg::ST_IDLE;
						else if (last) state_d = tfst_pkg::ST_APPLY;
					end
					tfst_pkg::OP_TICK: begin
						if (last) state_d = tfst_pkg::ST_IDLE;
					end
					tfst_pkg::OP_QUERY: begin
						if (qmatch || last) state_d = tfst_pkg::ST_RESULT;
					end
					default: state_d = tfst_pkg::ST_IDLE;
				endcase
			end
			tfst_pkg::ST_APPLY: state_d = tfst_pkg::ST_IDLE;
			tfst_pkg::ST_RESULT: begin
				if (out_free) state_d = tfst_pkg::ST_IDLE;
			end
			default: state_d = tfst_pkg::ST_IDLE;
		endcase
	end

	// handshake and slot write control
	always_comb begin
		s_tready = (state_q == tfst_pkg::ST_IDLE);
		accept   = s_tvalid && s_tready;
		out_free = !m_valid_q || m_tready;
		out_load = (state_q == tfst_pkg::ST_RESULT) && out_free;
		ent_we   = 1'b0;
		rem_we   = 1'b0;
		wr_idx   = idx_q;
		rem_wval = duration_q;
		track    = 1'b0;
		case (state_q)
			tfst_pkg::ST_SCAN: begin
				case (op_q)
					tfst_pkg::OP_EMIT: begin
						if (exact) begin
							rem_we = 1'b1;
						end else if (!cur_active) begin
							ent_we = 1'b1;
						end else begin
							track = better;
						end
					end
					tfst_pkg::OP_TICK: begin
						rem_we   = 1'b1;
						rem_wval = tick_val;
					end
					default: ;
				endcase
			end
			tfst_pkg::ST_APPLY: begin
				ent_we = 1'b1;
				wr_idx = victim_q;
			end
			default: ;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tfst_pkg::ST_IDLE;
			idx_q      <= '0;
			have_q     <= 1'b0;
			duration_q <= tfst_pkg::DURATION_RESET;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) duration_q <= cfg_wdata;
			if (accept) begin
				idx_q  <= '0;
				have_q <= 1'b0;
			end else if (state_q == tfst_pkg::ST_SCAN) begin
				idx_q <= idx_q + 1'b1;
				if (track) have_q <= 1'b1;
			end
			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// latched word, eviction candidate and results
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= s_tuser;
			fk_q <= s_tdata[1:0];
			tc_q <= s_tdata[5:2];
			id_q <= s_tdata[13:6];
			dt_q <= s_tdata[29:14];
		end
		if (track) begin
			victim_q <= idx_q;
			best_q   <= rem_cur;
		end
		if (state_q == tfst_pkg::ST_SCAN && op_q == tfst_pkg::OP_QUERY) begin
			res_hit_q  <= qmatch;
			res_kind_q <= qmatch ? slot_flash_q[idx_q] : '0;
		end
		if (out_load) begin
			m_hit_q  <= res_hit_q;
			m_kind_q <= res_kind_q;
		end
	end

	// remaining time, cleared at reset so every slot starts free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) slot_rem_q[i] <= '0;
		end else if (ent_we || rem_we) begin
			slot_rem_q[wr_idx] <= rem_wval;
		end
	end

	// slot entry fields
	always_ff @(posedge clk) begin
		if (ent_we) begin
			slot_flash_q[wr_idx]  <= fk_q;
			slot_target_q[wr_idx] <= tc_q;
			slot_ident_q[wr_idx]  <= id_q;
		end
	end

	// result port
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(tfst_pkg::M_TDATA_W - tfst_pkg::FLASH_W){1'b0}}, m_kind_q};
	assign m_tuser  = m_hit_q;

endmodule

`default_nettype wire

/* src/tfst_checker.sv */
// tfst_checker: port-level checks of the timed flash slot table, bound to the top level
// depends on tfst_pkg and timed_flash_slot_table
`default_nettype none

module tfst_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic [0:0]  m_tuser
);

	// a result word waits until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// a known operation leaves s_tready low in the cycle after it is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == tfst_pkg::OP_EMIT || s_tuser == tfst_pkg::OP_TICK
		|| s_tuser == tfst_pkg::OP_QUERY) |=> !s_tready)
		else $error("input accepted again without a scan");

	// no result can appear in the cycle right after a word is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared before the scan");

	// a miss reports kind zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("miss with nonzero kind");

	// a stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

endmodule

bind timed_flash_slot_table tfst_checker u_tfst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tuser   (s_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);

`default_nettype wire

/* bench/timed_flash_slot_table_tb.sv */
`timescale 1ns / 1ps
// timed_flash_slot_table_tb: self-checking bench for the timed flash slot table
// drives emit/tick/query and unused-kind words with bursty timing, predicts each query result
// and checks it against the result stream; depends on tfst_pkg and the block

module timed_flash_slot_table_tb;

	localparam int SLOTS = 4;
	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD = 400;
	localparam tfst_pkg::op_t OP_UNUSED = 2'd3;

	// one input word, field by field
	typedef struct packed {
		tfst_pkg::op_t kind;
		logic [tfst_pkg::FLASH_W-1:0] flash;
		logic [tfst_pkg::TARGET_W-1:0] target;
		logic [tfst_pkg::IDENT_W-1:0] ident;
		logic [tfst_pkg::TIME_W-1:0] elapsed;
	} flash_word_t;

	// one expected query answer
	typedef struct packed {
		logic hit;
		logic [tfst_pkg::FLASH_W-1:0] hit_kind;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b1;
	logic [7:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_wen = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// shadow copy of the slot table and its duration register
	logic [tfst_pkg::FLASH_W-1:0] shadow_flash[SLOTS] = '{default: '0};
	logic [tfst_pkg::TARGET_W-1:0] shadow_target[SLOTS] = '{default: '0};
	logic [tfst_pkg::IDENT_W-1:0] shadow_ident[SLOTS] = '{default: '0};
	logic [tfst_pkg::TIME_W-1:0] shadow_left[SLOTS] = '{default: '0};
	logic [tfst_pkg::TIME_W-1:0] shadow_duration = tfst_pkg::DURATION_RESET;

	flash_word_t word_q[$];
	answer_t answer_q[$];
	flash_word_t offered;

	int unsigned fail_count = 0;
	int unsigned words_taken = 0;
	int unsigned answers_seen = 0;
	int unsigned hits_seen = 0;
	int unsigned long_holds = 0;
	int unsigned cfg_writes = 0;

	timed_flash_slot_table #(
		.SLOT_COUNT(SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic flash_word_t mk(tfst_pkg::op_t kind, int flash, int target, int ident,
		int elapsed);
		flash_word_t w;
		w.kind = kind;
		w.flash = flash[tfst_pkg::FLASH_W-1:0];
		w.target = target[tfst_pkg::TARGET_W-1:0];
		w.ident = ident[tfst_pkg::IDENT_W-1:0];
		w.elapsed = elapsed[tfst_pkg::TIME_W-1:0];
		return w;
	endfunction

	// apply one accepted word to the shadow table, queue an answer for a query
	task automatic apply_word(flash_word_t w);
		int victim;
		bit have;
		bit restarted;
		answer_t a;
		victim = 0;
		have = 0;
		restarted = 0;
		case (w.kind)
			tfst_pkg::OP_EMIT: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (shadow_left[i] != 0 && shadow_flash[i] == w.flash &&
					    shadow_target[i] == w.target && shadow_ident[i] == w.ident) begin
						shadow_left[i] = shadow_duration;
						restarted = 1;
						break;
					end
					// scan stops at the first free slot
					if (shadow_left[i] == 0) begin
						victim = i;
						have = 1;
						break;
					end
					if (!have || shadow_left[i] < shadow_left[victim]) begin
						victim = i;
						have = 1;
					end
				end
				if (!restarted) begin
					shadow_flash[victim] = w.flash;
					shadow_target[victim] = w.target;
					shadow_ident[victim] = w.ident;
					shadow_left[victim] = shadow_duration;
				end
			end
			tfst_pkg::OP_TICK: begin
				for (int i = 0; i < SLOTS; i++)
					shadow_left[i] = (shadow_left[i] > w.elapsed) ? shadow_left[i] - w.elapsed : '0;
			end
			tfst_pkg::OP_QUERY: begin
				a = '0;
				for (int i = 0; i < SLOTS; i++) begin
					// negative stored id matches any query id
					if (shadow_left[i] != 0 && shadow_target[i] == w.target &&
					    (shadow_ident[i][tfst_pkg::IDENT_W-1] || shadow_ident[i] == w.ident)) begin
						a.hit = 1'b1;
						a.hit_kind = shadow_flash[i];
						break;
					end
				end
				answer_q.push_back(a);
			end
			default: ;
		endcase
	endtask

	// random word biased toward a few targets and ids so queries hit
	function automatic flash_word_t random_word(int dur);
		flash_word_t w;
		int r;
		int pick;
		r = $urandom_range(0, 99);
		w.kind = (r < 36) ? tfst_pkg::OP_EMIT : (r < 56) ? tfst_pkg::OP_TICK :
			(r < 96) ? tfst_pkg::OP_QUERY : OP_UNUSED;
		pick = $urandom_range(0, 3);
		w.flash = pick[tfst_pkg::FLASH_W-1:0];
		pick = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
		w.target = pick[tfst_pkg::TARGET_W-1:0];
		if ($urandom_range(0, 9) < 6)
			pick = $urandom_range(0, 5) - 2;
		else
			pick = $urandom_range(0, 255);
		w.ident = pick[tfst_pkg::IDENT_W-1:0];
		if (w.kind == tfst_pkg::OP_TICK && dur > 0 && $urandom_range(0, 4) != 0)
			pick = $urandom_range(0, dur / 3 + 1);
		else
			pick = $urandom_range(0, 65535);
		w.elapsed = pick[tfst_pkg::TIME_W-1:0];
		return w;
	endfunction

	task automatic wait_idle();
		while (word_q.size() != 0 || s_tvalid || answer_q.size() != 0)
			@(negedge clk);
		// emits and ticks leave nothing to wait on, so give the scan time to finish
		repeat (16) @(negedge clk);
	endtask

	task automatic write_duration(int value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value[15:0];
		shadow_duration = value[15:0];
		cfg_writes++;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// sender: bursts of words separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin : sender
		logic valid_next;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				apply_word(offered);
				words_taken++;
			end
			valid_next = s_tvalid && !s_tready;
			if (!valid_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (word_q.size() > 0) begin
					offered = word_q.pop_front();
					s_tdata <= {2'b00, offered.elapsed, offered.ident, offered.target, offered.flash};
					s_tuser <= offered.kind;
					valid_next = 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end
			end
			s_tvalid <= valid_next;
		end
	end

	// receiver: changing stall pattern plus an occasional long hold-off
	int unsigned rx_cycle = 0;
	int rx_mode = 0;
	int hold_left = 0;
	always @(posedge clk) begin : receiver
		logic ready_next;
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle % 4000 == 1500) begin
				hold_left = LONG_HOLD;
				long_holds++;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else begin
				if (rx_cycle % 48 == 0)
					rx_mode = $urandom_range(0, 3);
				case (rx_mode)
					0: ready_next = 1'b1;
					1: ready_next = ($urandom_range(0, 1) != 0);
					2: ready_next = ($urandom_range(0, 3) == 0);
					default: ready_next = rx_cycle[2];
				endcase
			end
			m_tready <= ready_next;
		end
	end

	// result checker
	always @(posedge clk) begin : result_check
		answer_t a;
		if (arst_n && m_tvalid && m_tready) begin
			if (answer_q.size() == 0) begin
				$error("unexpected result word: hit %0d hit_kind %0d", m_tuser[0], m_tdata[1:0]);
				fail_count++;
			end else begin
				a = answer_q.pop_front();
				answers_seen++;
				if (a.hit)
					hits_seen++;
				if (m_tuser[0] !== a.hit) begin
					$error("hit: expected %0d, actual %0d", a.hit, m_tuser[0]);
					fail_count++;
				end
				if (m_tdata[1:0] !== a.hit_kind) begin
					$error("hit_kind: expected %0d, actual %0d", a.hit_kind, m_tdata[1:0]);
					fail_count++;
				end
				if (m_tdata[7:2] !== 6'd0) begin
					$error("m_tdata pad: expected 0, actual %0d", m_tdata[7:2]);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d quiet cycles, %0d results outstanding",
					quiet_cycles, answer_q.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		int durs[7];
		int count;
		durs = '{1, 65535, 0, 37, 0, 500, 12};
		durs[4] = $urandom_range(1, 65535);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at the reset duration
		word_q.push_back(mk(tfst_pkg::OP_QUERY, 0, 0, 0, 0));        // miss on empty table
		word_q.push_back(mk(tfst_pkg::OP_QUERY, 3, 15, -128, 65535));
		word_q.push_back(mk(tfst_pkg::OP_EMIT, 0, 0, 0, 0));
		word_q.push_back(mk(tfst_pkg::OP_QUERY, 0, 0, 0, 0));
		word_q.push_back(mk(tfst_pkg::OP_EMIT, 3, 15, -128, 65535)); // wildcard entry
		word_q.push_back(mk(tfst_pkg::OP_QUERY, 0, 15, 127, 0));
		word_q.push_back(mk(tfst_pkg::OP_EMIT, 2, 15, 127, 0));
		word_q.push_back(mk(tfst_pkg::OP_QUERY, 1, 15, 127, 0));
		word_q.push_back(mk(tfst_pkg::OP_TICK, 0, 0, 0, 100));
		word_q.push_back(mk(tfst_pkg::OP_EMIT, 0, 0, 0, 0));  // restart of a matching slot
		word_q.push_back(mk(tfst_pkg::OP_EMIT, 1, 5, -1, 0));
		word_q.push_back(mk(tfst_pkg::OP_EMIT, 2, 9, 1, 0));  // eviction tie, lowest index goes
		word_q.push_back(mk(tfst_pkg::OP_QUERY, 0, 15, 5, 0));
		word_q.push_back(mk(tfst_pkg::OP_QUERY, 0, 9, 1, 0));
		word_q.push_back(mk(tfst_pkg::OP_TICK, 3, 15, -1, 0));
		word_q.push_back(mk(OP_UNUSED, 3, 15, -1, 65535));    // unused kind does nothing
		word_q.push_back(mk(tfst_pkg::OP_TICK, 0, 0, 0, 65535));
		word_q.push_back(mk(tfst_pkg::OP_QUERY, 0, 0, 0, 0));
		// free slot ahead of a live match
		word_q.push_back(mk(tfst_pkg::OP_EMIT, 0, 3, 7, 0));
		word_q.push_back(mk(tfst_pkg::OP_TICK, 0, 0, 0, 300));
		word_q.push_back(mk(tfst_pkg::OP_EMIT, 1, 3, 8, 0));
		word_q.push_back(mk(tfst_pkg::OP_TICK, 0, 0, 0, 200));
		word_q.push_back(mk(tfst_pkg::OP_EMIT, 1, 3, 8, 0));
		word_q.push_back(mk(tfst_pkg::OP_TICK, 0, 0, 0, 250));
		word_q.push_back(mk(tfst_pkg::OP_QUERY, 2, 3, 8, 0));
		wait_idle();

		// random phases, one duration setting each
		foreach (durs[p]) begin
			write_duration(durs[p]);
			@(negedge clk);
			count = (durs[p] == 0) ? 60 : 130;
			for (int k = 0; k < count; k++)
				word_q.push_back(random_word(durs[p]));
			wait_idle();
		end

		$display("%0d words accepted over %0d duration settings, %0d long receiver holds",
			words_taken, cfg_writes + 1, long_holds);
		$display("%0d query results checked, %0d of them hits", answers_seen, hits_seen);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
src/tfst_pkg.sv
src/timed_flash_slot_table.sv
src/tfst_checker.sv
bench/timed_flash_slot_table_tb.sv
